// ----- design/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the stream find-and-replace block.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

    localparam int BYTE_W    = 8;
    localparam int TEXT_W    = 64;   // pattern and replacement registers
    localparam int LEN_W     = 4;    // length registers and result counts
    localparam int CFG_IDX_W = 8;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPL     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPL_LEN = 8'd3;

    // configuration as seen by the datapath, lengths already clamped
    typedef struct packed {
        logic [TEXT_W-1:0] pattern;
        logic [LEN_W-1:0]  pat_len;
        logic [TEXT_W-1:0] repl;
        logic [LEN_W-1:0]  repl_len;
        logic              clear_window;
    } t_cfg;

    // control half of a result group handed to the output buffer
    typedef struct packed {
        logic             load;
        logic [LEN_W-1:0] count;
        logic             last;
        logic             marker;
    } t_res_ctl;

endpackage

`default_nettype wire

// ----- design/sfr_config.sv -----
// ----------------------------------------------------------------------------
// sfr_config
// Configuration registers, write decode and length clamping.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_config #(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_wr,
    input  wire [sfr_pkg::CFG_IDX_W-1:0]  i_index,
    input  wire [sfr_pkg::TEXT_W-1:0]     i_data,
    output sfr_pkg::t_cfg                 o_cfg
);

    localparam logic [sfr_pkg::LEN_W-1:0] MAXP = sfr_pkg::LEN_W'(MAX_PATTERN);
    localparam logic [sfr_pkg::LEN_W-1:0] MAXR = sfr_pkg::LEN_W'(MAX_REPLACEMENT);

    logic [sfr_pkg::TEXT_W-1:0] r_pattern;
    logic [sfr_pkg::LEN_W-1:0]  r_pat_len;
    logic [sfr_pkg::TEXT_W-1:0] r_repl;
    logic [sfr_pkg::LEN_W-1:0]  r_repl_len;
    logic                       r_clear;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern  <= '0;
            r_pat_len  <= sfr_pkg::LEN_W'(1);
            r_repl     <= '0;
            r_repl_len <= '0;
            r_clear    <= 1'b0;
        end else begin
            r_clear <= 1'b0;
            if (i_wr) begin
                unique case (i_index)
                    sfr_pkg::CFG_PATTERN:  r_pattern <= i_data;
                    sfr_pkg::CFG_PAT_LEN: begin
                        r_pat_len <= i_data[sfr_pkg::LEN_W-1:0];
                        r_clear   <= 1'b1;
                    end
                    sfr_pkg::CFG_REPL:     r_repl <= i_data;
                    sfr_pkg::CFG_REPL_LEN: r_repl_len <= i_data[sfr_pkg::LEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        o_cfg.pattern      = r_pattern;
        o_cfg.repl         = r_repl;
        o_cfg.clear_window = r_clear;
        // zero length behaves as one
        if (r_pat_len == '0)
            o_cfg.pat_len = sfr_pkg::LEN_W'(1);
        else if (r_pat_len > MAXP)
            o_cfg.pat_len = MAXP;
        else
            o_cfg.pat_len = r_pat_len;
        o_cfg.repl_len = (r_repl_len > MAXR) ? MAXR : r_repl_len;
    end

endmodule

`default_nettype wire

// ----- design/sfr_matcher.sv -----
// ----------------------------------------------------------------------------
// sfr_matcher
// Pending-byte window, parallel pattern compare and result group build.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_matcher #(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8,
    localparam int BUF_D = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  sfr_pkg::t_cfg                    i_cfg,
    input  wire                              i_accept,
    input  wire [sfr_pkg::BYTE_W-1:0]        i_byte,
    input  wire                              i_last,
    output sfr_pkg::t_res_ctl                o_ctl,
    output logic [BUF_D*sfr_pkg::BYTE_W-1:0] o_bytes
);

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);

    logic [sfr_pkg::BYTE_W-1:0] r_win [MAX_PATTERN];
    logic [sfr_pkg::BYTE_W-1:0] n_win [MAX_PATTERN];
    logic [CNT_W-1:0]           r_cnt;
    logic [CNT_W-1:0]           n_cnt;

    logic [sfr_pkg::BYTE_W-1:0] w1 [MAX_PATTERN];
    logic [CNT_W-1:0]           plen;
    logic [CNT_W-1:0]           c0;
    logic [CNT_W-1:0]           c1;
    logic                       full;
    logic                       match;
    logic                       hit;
    logic [sfr_pkg::LEN_W-1:0]  n_res;

    always_comb begin
        plen = CNT_W'(i_cfg.pat_len);
        // a pattern length write just before empties the window
        c0   = (i_cfg.clear_window || r_cnt >= plen) ? '0 : r_cnt;
        c1   = c0 + 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
            w1[i] = (CNT_W'(i) == c0) ? i_byte : r_win[i];
        full  = (c1 == plen);
        match = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (CNT_W'(i) < plen && w1[i] != i_cfg.pattern[8*i +: 8])
                match = 1'b0;
        end
        hit = full && match;

        // next window: cleared on a hit, shifted by one on a miss
        for (int i = 0; i < MAX_PATTERN - 1; i++)
            n_win[i] = (full && !hit) ? w1[i+1] : w1[i];
        n_win[MAX_PATTERN-1] = w1[MAX_PATTERN-1];
        if (hit)
            n_cnt = '0;
        else if (full)
            n_cnt = plen - 1'b1;
        else
            n_cnt = c1;
        if (i_last)
            n_cnt = '0;

        // a miss emits the oldest byte, and at end of string the whole window
        if (hit)
            n_res = i_cfg.repl_len;
        else if (full)
            n_res = i_last ? sfr_pkg::LEN_W'(plen) : sfr_pkg::LEN_W'(1);
        else
            n_res = i_last ? sfr_pkg::LEN_W'(c1) : '0;

        for (int i = 0; i < BUF_D; i++) begin
            o_bytes[8*i +: 8] = '0;
            if (hit) begin
                if (i < MAX_REPLACEMENT)
                    o_bytes[8*i +: 8] = i_cfg.repl[8*i +: 8];
            end else begin
                if (i < MAX_PATTERN)
                    o_bytes[8*i +: 8] = w1[i];
            end
        end

        // deleted match on the final byte leaves only the end marker
        o_ctl.marker = i_last && (n_res == '0);
        o_ctl.count  = o_ctl.marker ? sfr_pkg::LEN_W'(1) : n_res;
        o_ctl.last   = i_last;
        o_ctl.load   = i_accept && (o_ctl.count != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_accept) begin
            r_cnt <= n_cnt;
        end else if (i_cfg.clear_window) begin
            r_cnt <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            for (int i = 0; i < MAX_PATTERN; i++)
                r_win[i] <= n_win[i];
        end
    end

endmodule

`default_nettype wire

// ----- design/sfr_out_buffer.sv -----
// ----------------------------------------------------------------------------
// sfr_out_buffer
// Result register: holds one result group and hands it out a byte a transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_out_buffer #(
    parameter int BUF_D = 8
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  sfr_pkg::t_res_ctl                i_ctl,
    input  wire [BUF_D*sfr_pkg::BYTE_W-1:0]  i_bytes,
    output logic                             o_free,
    output logic                             o_res_valid,
    input  wire                              i_res_ready,
    output logic [sfr_pkg::BYTE_W-1:0]       o_out_byte,
    output logic                             o_out_valid,
    output logic                             o_out_last
);

    localparam int BCNT_W = $clog2(BUF_D + 1);

    logic [sfr_pkg::BYTE_W-1:0] r_data [BUF_D];
    logic [BCNT_W-1:0]          r_cnt;
    logic                       r_last;
    logic                       r_marker;
    logic                       pop;

    assign pop    = (r_cnt != '0) && i_res_ready;
    // free when empty, or once the final byte of the group goes out this cycle
    assign o_free = (r_cnt == '0) || ((r_cnt == BCNT_W'(1)) && i_res_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.load) begin
            r_cnt <= BCNT_W'(i_ctl.count);
        end else if (pop) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            for (int i = 0; i < BUF_D; i++)
                r_data[i] <= i_bytes[8*i +: 8];
            r_last   <= i_ctl.last;
            r_marker <= i_ctl.marker;
        end else if (pop) begin
            for (int i = 0; i < BUF_D - 1; i++)
                r_data[i] <= r_data[i+1];
        end
    end

    assign o_res_valid = (r_cnt != '0);
    assign o_out_byte  = r_marker ? '0 : r_data[0];
    assign o_out_valid = !r_marker;
    assign o_out_last  = r_last && (r_cnt == BCNT_W'(1));

endmodule

`default_nettype wire

// ----- design/stream_find_and_replace.sv -----
// ----------------------------------------------------------------------------
// stream_find_and_replace
// Byte-stream find and replace with an end-of-string flag.
// ----------------------------------------------------------------------------
// Takes one byte per transfer and keeps up to the pattern length of pending
// bytes in a window; a full window equal to the pattern is replaced (leftmost,
// non-overlapping), otherwise its oldest byte goes out, and the final byte of a
// string flushes the window. Each accepted byte makes a group of zero to BUF_D
// (eight by default) results that the output register hands out one per cycle
// while i_res_ready is high, taking the next byte as the last one goes out:
// plain text streams at one byte per cycle, and only replacement expansion, an
// end-of-string flush or a stalled result side holds off the input. A string
// whose final byte leaves nothing to emit ends in a single result with
// o_out_valid low and o_out_last high. Write the configuration only while
// the block is idle; writing the pattern length discards pending window bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_find_and_replace #(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // configuration write
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire [sfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [sfr_pkg::TEXT_W-1:0]     i_cfg_data,
    // input stream
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire [sfr_pkg::BYTE_W-1:0]     i_in_byte,
    input  wire                           i_in_last,
    // result stream
    output logic                          o_res_valid,
    input  wire                           i_res_ready,
    output logic [sfr_pkg::BYTE_W-1:0]    o_out_byte,
    output logic                          o_out_valid,
    output logic                          o_out_last
);

    localparam int BUF_D = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;

    sfr_pkg::t_cfg                    cfg;
    sfr_pkg::t_res_ctl                res_ctl;
    logic [BUF_D*sfr_pkg::BYTE_W-1:0] res_bytes;
    logic                             accept;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;

    sfr_config #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_config (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    sfr_matcher #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_matcher (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (accept),
        .i_byte   (i_in_byte),
        .i_last   (i_in_last),
        .o_ctl    (res_ctl),
        .o_bytes  (res_bytes)
    );

    sfr_out_buffer #(
        .BUF_D (BUF_D)
    ) u_out_buffer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (res_ctl),
        .i_bytes     (res_bytes),
        .o_free      (o_in_ready),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_out_byte  (o_out_byte),
        .o_out_valid (o_out_valid),
        .o_out_last  (o_out_last)
    );

endmodule

`default_nettype wire

// ----- design/sfr_checker.sv -----
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks for stream_find_and_replace, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_checker (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        o_in_ready,
    input wire                        o_res_valid,
    input wire                        i_res_ready,
    input wire [sfr_pkg::BYTE_W-1:0]  o_out_byte,
    input wire                        o_out_valid,
    input wire                        o_out_last
);

    // a stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_out_byte)
            && $stable(o_out_valid) && $stable(o_out_last))
        else $error("stalled result changed");

    // an end marker only ever closes a string
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_out_valid |-> o_out_last)
        else $error("end marker without last flag");

    // a pending result that is not taken blocks the input
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |-> !o_in_ready)
        else $error("input taken while result stalled");

    // nothing left over once reset has been applied
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_res_valid && o_in_ready)
        else $error("result pending after reset");

endmodule

bind stream_find_and_replace sfr_checker u_sfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_res_valid (o_res_valid),
    .i_res_ready (i_res_ready),
    .o_out_byte  (o_out_byte),
    .o_out_valid (o_out_valid),
    .o_out_last  (o_out_last)
);

`default_nettype wire

// ----- bench/stream_find_and_replace_tb.sv -----
// ----------------------------------------------------------------------------
// stream_find_and_replace_tb
// Self-checking bench for the byte-stream find-and-replace block.
// ----------------------------------------------------------------------------
// A short scripted sequence exercises reset values, length clamping, deletion,
// end markers, ignored register indexes and register writes part-way through a
// string. Randomised text follows, built mostly from whole and partial copies
// of the current pattern, under three idling profiles. Each output transfer is
// checked against the script or the bench's model of window and replacement.
// ----------------------------------------------------------------------------

module stream_find_and_replace_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT      = 5000;   // cycles without any transfer
    localparam int HOLD_LEN   = 400;
    localparam int BLOCK_SIZE = 40;

    // register indexes beyond the map, to be ignored
    localparam logic [sfr_pkg::CFG_IDX_W-1:0] CFG_BAD_TOP  = 8'hFF;
    localparam logic [sfr_pkg::CFG_IDX_W-1:0] CFG_BAD_NEXT = 8'h04;

    typedef struct packed {
        logic [sfr_pkg::BYTE_W-1:0] ch;
        logic                       has_ch;
        logic                       ends;
    } t_char_out;

    typedef enum logic {ROW_BYTE, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind                     kind;
        logic [sfr_pkg::CFG_IDX_W-1:0] idx;
        logic [sfr_pkg::TEXT_W-1:0]    data;
        logic [sfr_pkg::BYTE_W-1:0]    ch;
        logic                          fin;
        logic                          typed;
        t_char_out                     want;
    } t_row;

    localparam t_char_out NONE   = '{8'h00, 1'b0, 1'b0};
    localparam t_char_out MARKER = '{8'h00, 1'b0, 1'b1};

    localparam int N_ROWS = 38;
    localparam t_row SCRIPT [N_ROWS] = '{
        // reset settings: pattern 00, length 1, nothing to put in its place
        '{ROW_BYTE,  '0, 64'h0, 8'h00, 1'b1, 1'b1, MARKER},
        '{ROW_BYTE,  '0, 64'h0, 8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1}},
        '{ROW_BYTE,  '0, 64'h0, 8'h00, 1'b0, 1'b0, NONE},
        '{ROW_BYTE,  '0, 64'h0, 8'h41, 1'b0, 1'b1, '{8'h41, 1'b1, 1'b0}},
        // "ab" -> "YZ"
        '{ROW_WRITE, sfr_pkg::CFG_PATTERN,  64'h6261, 8'h00, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, sfr_pkg::CFG_PAT_LEN,  64'h2,    8'h00, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, sfr_pkg::CFG_REPL,     64'h5A59, 8'h00, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, sfr_pkg::CFG_REPL_LEN, 64'h2,    8'h00, 1'b0, 1'b0, NONE},
        '{ROW_BYTE,  '0, 64'h0, 8'h78, 1'b0, 1'b0, NONE},
        '{ROW_BYTE,  '0, 64'h0, 8'h61, 1'b0, 1'b0, NONE},
        '{ROW_BYTE,  '0, 64'h0, 8'h62, 1'b0, 1'b0, NONE},
        '{ROW_BYTE,  '0, 64'h0, 8'h61, 1'b1, 1'b0, NONE},
        // pattern length rewritten with a byte pending: the byte is dropped
        '{ROW_BYTE,  '0, 64'h0, 8'h61, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, sfr_pkg::CFG_PAT_LEN,  64'h1,    8'h00, 1'b0, 1'b0, NONE},
        '{ROW_BYTE,  '0, 64'h0, 8'h62, 1'b1, 1'b0, NONE},
        // pattern rewritten with a byte pending: used at the next compare
        '{ROW_WRITE, sfr_pkg::CFG_PAT_LEN,  64'h2,    8'h00, 1'b0, 1'b0, NONE},
        '{ROW_BYTE,  '0, 64'h0, 8'h61, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, sfr_pkg::CFG_PATTERN,  64'h6361, 8'h00, 1'b0, 1'b0, NONE},
        '{ROW_BYTE,  '0, 64'h0, 8'h63, 1'b1, 1'b0, NONE},
        // oversize lengths clamp to eight
        '{ROW_WRITE, sfr_pkg::CFG_PATTERN,  64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, sfr_pkg::CFG_PAT_LEN,  64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, sfr_pkg::CFG_REPL,     64'h0807_0605_0403_0201, 8'h00, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, sfr_pkg::CFG_REPL_LEN, 64'hF,    8'h00, 1'b0, 1'b0, NONE},
        '{ROW_BYTE,  '0, 64'h0, 8'hFF, 1'b0, 1'b0, NONE},
        '{ROW_BYTE,  '0, 64'h0, 8'hFF, 1'b0, 1'b0, NONE},
        '{ROW_BYTE,  '0, 64'h0, 8'hFF, 1'b0, 1'b0, NONE},
        '{ROW_BYTE,  '0, 64'h0, 8'hFF, 1'b0, 1'b0, NONE},
        '{ROW_BYTE,  '0, 64'h0, 8'hFF, 1'b0, 1'b0, NONE},
        '{ROW_BYTE,  '0, 64'h0, 8'hFF, 1'b0, 1'b0, NONE},
        '{ROW_BYTE,  '0, 64'h0, 8'hFF, 1'b0, 1'b0, NONE},
        '{ROW_BYTE,  '0, 64'h0, 8'hFF, 1'b1, 1'b0, NONE},
        // zero pattern length acts as one; matches deleted
        '{ROW_WRITE, sfr_pkg::CFG_PAT_LEN,  64'h0,    8'h00, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, sfr_pkg::CFG_REPL_LEN, 64'h0,    8'h00, 1'b0, 1'b0, NONE},
        '{ROW_BYTE,  '0, 64'h0, 8'hFF, 1'b1, 1'b1, MARKER},
        '{ROW_BYTE,  '0, 64'h0, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1}},
        // writes to unmapped indexes change nothing
        '{ROW_WRITE, CFG_BAD_TOP,  64'h1,    8'h00, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, CFG_BAD_NEXT, 64'h0,    8'h00, 1'b0, 1'b0, NONE},
        '{ROW_BYTE,  '0, 64'h0, 8'hFF, 1'b1, 1'b1, MARKER}
    };

    localparam int SEND_IDLE [3] = '{13, 62, 0};
    localparam int RECV_IDLE [3] = '{62, 13, 0};

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [sfr_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [sfr_pkg::TEXT_W-1:0]    i_cfg_data  = '0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_ready;
    logic [sfr_pkg::BYTE_W-1:0]    i_in_byte   = '0;
    logic                          i_in_last   = 1'b0;
    logic                          o_res_valid;
    logic                          i_res_ready = 1'b0;
    logic [sfr_pkg::BYTE_W-1:0]    o_out_byte;
    logic                          o_out_valid;
    logic                          o_out_last;

    stream_find_and_replace i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_out_byte  (o_out_byte),
        .o_out_valid (o_out_valid),
        .o_out_last  (o_out_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // bench copy of the block's settings and window
    logic [sfr_pkg::TEXT_W-1:0] pat_reg  = '0;
    logic [sfr_pkg::LEN_W-1:0]  plen_reg = 4'd1;
    logic [sfr_pkg::TEXT_W-1:0] repl_reg = '0;
    logic [sfr_pkg::LEN_W-1:0]  rlen_reg = '0;
    logic [sfr_pkg::BYTE_W-1:0] win [8];
    int                         win_cnt  = 0;

    t_char_out text_due [$];
    int        fail_count = 0;
    int        bytes_sent = 0;
    int        send_idle  = 0;
    int        recv_idle  = 0;
    int        hold_token = 0;
    int        hold_seen  = 0;
    int        hold_left  = 0;
    int        quiet_cycles = 0;

    function automatic int eff_plen();
        if (plen_reg == 0) return 1;
        if (plen_reg > 8) return 8;
        return plen_reg;
    endfunction

    // window update for one byte; grp gets the characters it releases
    task automatic apply_byte(input logic [sfr_pkg::BYTE_W-1:0] ch, input logic fin,
                              ref t_char_out grp [$]);
        int plen;
        int rlen;
        bit hit;
        grp.delete();
        plen = eff_plen();
        rlen = (rlen_reg > 8) ? 8 : rlen_reg;
        if (win_cnt >= plen) win_cnt = 0;
        win[win_cnt] = ch;
        win_cnt++;
        if (win_cnt == plen) begin
            hit = 1'b1;
            for (int i = 0; i < plen; i++)
                if (win[i] != pat_reg[8*i +: 8]) hit = 1'b0;
            if (hit) begin
                for (int i = 0; i < rlen; i++)
                    grp.push_back('{repl_reg[8*i +: 8], 1'b1, 1'b0});
                win_cnt = 0;
            end else begin
                grp.push_back('{win[0], 1'b1, 1'b0});
                for (int i = 1; i < win_cnt; i++) win[i-1] = win[i];
                win_cnt--;
            end
        end
        if (fin) begin
            for (int i = 0; i < win_cnt; i++) grp.push_back('{win[i], 1'b1, 1'b0});
            win_cnt = 0;
            if (grp.size() == 0) grp.push_back(NONE);
            grp[grp.size()-1].ends = 1'b1;
        end
    endtask

    // valid is left high after the transfer; the next call decides
    task automatic send_byte(input logic [sfr_pkg::BYTE_W-1:0] ch, input logic fin);
        while ($urandom_range(0, 99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= ch;
        i_in_last  <= fin;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic feed(input logic [sfr_pkg::BYTE_W-1:0] ch, input logic fin);
        t_char_out grp [$];
        send_byte(ch, fin);
        apply_byte(ch, fin, grp);
        foreach (grp[i]) text_due.push_back(grp[i]);
        bytes_sent++;
    endtask

    // register writes only once the output has drained
    task automatic cfg_write(input logic [sfr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sfr_pkg::TEXT_W-1:0] data);
        i_in_valid <= 1'b0;
        while (text_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            sfr_pkg::CFG_PATTERN:  pat_reg = data;
            sfr_pkg::CFG_PAT_LEN: begin
                plen_reg = data[sfr_pkg::LEN_W-1:0];
                win_cnt  = 0;
            end
            sfr_pkg::CFG_REPL:     repl_reg = data;
            sfr_pkg::CFG_REPL_LEN: rlen_reg = data[sfr_pkg::LEN_W-1:0];
            default: ;
        endcase
    endtask

    // a string built mostly from whole or broken copies of the pattern
    task automatic send_text(input int max_len, input logic finish);
        logic [sfr_pkg::BYTE_W-1:0] txt [$];
        int len;
        int plen;
        int cut;
        len  = $urandom_range(1, max_len);
        plen = eff_plen();
        while (txt.size() < len) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    for (int i = 0; i < plen; i++) txt.push_back(pat_reg[8*i +: 8]);
                end
                4, 5: begin
                    cut = (plen > 1) ? $urandom_range(1, plen - 1) : 0;
                    for (int i = 0; i < cut; i++) txt.push_back(pat_reg[8*i +: 8]);
                    txt.push_back(8'($urandom_range(0, 255)));
                end
                6, 7: txt.push_back(pat_reg[8*$urandom_range(0, plen - 1) +: 8]);
                default: txt.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        foreach (txt[i]) feed(txt[i], finish && (i == txt.size() - 1));
    endtask

    // result side: ready pattern, with a long hold on request
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        t_char_out want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (text_due.size() == 0) begin
                $display("%0t: unexpected transfer: expected none, actual byte=%h valid=%b last=%b",
                         $time, o_out_byte, o_out_valid, o_out_last);
                fail_count++;
            end else begin
                want = text_due.pop_front();
                if (o_out_byte !== want.ch) begin
                    $display("%0t: out_byte mismatch: expected %h, actual %h",
                             $time, want.ch, o_out_byte);
                    fail_count++;
                end
                if (o_out_valid !== want.has_ch) begin
                    $display("%0t: out_valid mismatch: expected %b, actual %b",
                             $time, want.has_ch, o_out_valid);
                    fail_count++;
                end
                if (o_out_last !== want.ends) begin
                    $display("%0t: out_last mismatch: expected %b, actual %b",
                             $time, want.ends, o_out_last);
                    fail_count++;
                end
            end
        end
        if ((i_in_valid && o_in_ready) || (o_res_valid && i_res_ready)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_char_out                  grp [$];
        logic [sfr_pkg::TEXT_W-1:0] d;
        int                         target;
        send_idle = SEND_IDLE[0];
        recv_idle = RECV_IDLE[0];
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_ROWS; r++) begin
            if (SCRIPT[r].kind == ROW_WRITE) begin
                cfg_write(SCRIPT[r].idx, SCRIPT[r].data);
            end else if (SCRIPT[r].typed) begin
                send_byte(SCRIPT[r].ch, SCRIPT[r].fin);
                apply_byte(SCRIPT[r].ch, SCRIPT[r].fin, grp);
                if (SCRIPT[r].want != NONE) text_due.push_back(SCRIPT[r].want);
                bytes_sent++;
            end else begin
                feed(SCRIPT[r].ch, SCRIPT[r].fin);
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            send_idle = SEND_IDLE[ph];
            recv_idle = RECV_IDLE[ph];
            for (int blk = 0; blk < 3; blk++) begin
                d = {$urandom, $urandom};
                cfg_write(sfr_pkg::CFG_PATTERN, d);
                d = {$urandom, $urandom};
                cfg_write(sfr_pkg::CFG_REPL, d);
                d = {$urandom, $urandom};
                d[sfr_pkg::LEN_W-1:0] = 4'($urandom_range(0, 15));
                cfg_write(sfr_pkg::CFG_REPL_LEN, d);
                d = {$urandom, $urandom};
                cfg_write(8'($urandom_range(sfr_pkg::CFG_REPL_LEN + 1, 255)), d);
                // leaving the length alone keeps any pending bytes in the window
                if (blk == 0 || $urandom_range(0, 3) != 0) begin
                    d = {$urandom, $urandom};
                    d[sfr_pkg::LEN_W-1:0] = ($urandom_range(0, 4) == 0)
                                            ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(1, 8));
                    cfg_write(sfr_pkg::CFG_PAT_LEN, d);
                end
                if (ph == 0 && blk == 0) hold_token++;
                target = bytes_sent + BLOCK_SIZE;
                while (bytes_sent < target) send_text(12, $urandom_range(0, 5) != 0);
            end
        end
        send_text(4, 1'b1);

        i_in_valid <= 1'b0;
        while (text_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- stream_find_and_replace.f -----
design/sfr_pkg.sv
design/sfr_config.sv
design/sfr_matcher.sv
design/sfr_out_buffer.sv
design/stream_find_and_replace.sv
design/sfr_checker.sv
bench/stream_find_and_replace_tb.sv
